### sv/str_pkg.sv
// ============================================================================
// str_pkg - segment tree range sum shared definitions
// Widths, request codes, tree node and memory request types.
// ============================================================================
package str_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int NODE_COUNT   = 2 * MAX_ELEMENTS - 1;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ADDR_W       = $clog2(NODE_COUNT);
    localparam int DATA_W       = 32;
    localparam int TYPE_W       = 2;
    localparam int STACK_DEPTH  = $clog2(MAX_ELEMENTS) + 1;
    localparam int SP_W         = $clog2(STACK_DEPTH);

    typedef enum logic [TYPE_W-1:0] {
        REQ_SET   = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [ADDR_W-1:0] id;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last;
    } t_node;

    typedef struct packed {
        t_node left;
        t_node right;
        logic  go_left;
        logic  leaf;
    } t_split;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_mem_req;

endpackage

### sv/str_if.sv
// ============================================================================
// str_if - segment tree range sum channels
// Request, response and configuration channels with valid/ready.
// ============================================================================
interface str_req_if;
    logic                       valid;
    logic                       ready;
    logic [str_pkg::TYPE_W-1:0] req_type;
    logic [str_pkg::IDX_W-1:0]  element_index;
    logic signed [31:0]         amount;
    logic [str_pkg::IDX_W-1:0]  range_low;
    logic [str_pkg::IDX_W-1:0]  range_high;

    modport source (output valid, req_type, element_index, amount, range_low, range_high,
                    input ready);
    modport sink   (input valid, req_type, element_index, amount, range_low, range_high,
                    output ready);
endinterface

interface str_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] range_sum;
    logic               status;

    modport source (output valid, range_sum, status, input ready);
    modport sink   (input valid, range_sum, status, output ready);
endinterface

interface str_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [str_pkg::CNT_W-1:0] elements_in_use;

    modport source (output valid, elements_in_use, input ready);
    modport sink   (input valid, elements_in_use, output ready);
endinterface

### sv/segment_tree_range_sum.sv
// ============================================================================
// segment_tree_range_sum - segment tree range sum with point update
// Node sums in one RAM, walked by an iterative sequencer.
// ============================================================================
// Usage:
//   i_req carries one request word: set element, add delta, or range query.
//   o_rsp returns exactly one word per request: range_sum and status.
//   i_cfg writes elements_in_use (0 taken as 1, clamped to MAX_ELEMENTS)
//   and always accepts; it must be used only while the block is idle.
// Request handling (d = tree depth, ceil(log2 elements_in_use), 10 at 1024):
//   add      : walks d+1 levels, one RAM read and write per level.
//   set      : leaf lookup then the add walk.
//   query    : one visited node per cycle, at most about 4*d nodes.
//   invalid index or unused type: no tree walk.
//   The single RAM port pair is shared by all walks; one request at a time.
// Reset and every configuration write start a clearing pass that zeroes
//   all node sums; i_req.ready stays low meanwhile.
// The response sits in an output register; the next request is taken while
//   it waits, and that request stalls at its end until o_rsp is free.
// ============================================================================
module segment_tree_range_sum (
    input  logic      i_clk,
    input  logic      i_rst_n,
    str_req_if.sink   i_req,
    str_rsp_if.source o_rsp,
    str_cfg_if.sink   i_cfg
);

    localparam logic [str_pkg::CNT_W-1:0]  MAX_CNT   = str_pkg::CNT_W'(str_pkg::MAX_ELEMENTS);
    localparam logic [str_pkg::ADDR_W-1:0] LAST_ADDR = str_pkg::ADDR_W'(str_pkg::NODE_COUNT - 1);

    logic [str_pkg::CNT_W-1:0]  r_count;
    logic                       r_clr;
    logic [str_pkg::ADDR_W-1:0] r_clr_addr;
    logic [str_pkg::CNT_W-1:0]  cfg_count;
    str_pkg::t_mem_req          mem;
    logic [str_pkg::DATA_W-1:0] rd_data;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (i_cfg.elements_in_use == '0) begin
            cfg_count = str_pkg::CNT_W'(1);
        end else if (i_cfg.elements_in_use > MAX_CNT) begin
            cfg_count = MAX_CNT;
        end else begin
            cfg_count = i_cfg.elements_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= MAX_CNT;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_count    <= cfg_count;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + str_pkg::ADDR_W'(1);
        end
    end

    str_ram #(
        .WIDTH (str_pkg::DATA_W),
        .DEPTH (str_pkg::NODE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_clr || mem.wr_en),
        .i_wr_addr (r_clr ? r_clr_addr : mem.wr_addr),
        .i_wr_data (r_clr ? '0 : mem.wr_data),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data)
    );

    str_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_run     (!r_clr),
        .i_count   (r_count),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem     (mem),
        .i_rd_data (rd_data)
    );

endmodule

### sv/str_ram.sv
// ============================================================================
// str_ram - generic single write port RAM
// One write and one read port, read data registered.
// ============================================================================
module str_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2047
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/str_split.sv
// ============================================================================
// str_split - node split unit
// Midpoint, child nodes in pre-order layout and path direction for a node.
// ============================================================================
module str_split (
    input  str_pkg::t_node              i_node,
    input  logic [str_pkg::IDX_W-1:0]   i_idx,
    output str_pkg::t_split             o_split
);

    logic [str_pkg::IDX_W-1:0] mid;
    logic [str_pkg::CNT_W-1:0] half;

    always_comb begin
        mid  = i_node.first + ((i_node.last - i_node.first) >> 1);
        half = str_pkg::CNT_W'(mid - i_node.first) + str_pkg::CNT_W'(1);

        o_split.left.id     = i_node.id + str_pkg::ADDR_W'(1);
        o_split.left.first  = i_node.first;
        o_split.left.last   = mid;
        o_split.right.id    = i_node.id + str_pkg::ADDR_W'({half, 1'b0});
        o_split.right.first = mid + str_pkg::IDX_W'(1);
        o_split.right.last  = i_node.last;
        o_split.go_left     = (i_idx <= mid);
        o_split.leaf        = (i_node.first >= i_node.last);
    end

endmodule

### sv/str_core.sv
// ============================================================================
// str_core - segment tree sequencer
// Walks the tree one node per step for point updates and range queries.
// ============================================================================
module str_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_run,
    input  logic [str_pkg::CNT_W-1:0]    i_count,
    str_req_if.sink                      i_req,
    str_rsp_if.source                    o_rsp,
    output str_pkg::t_mem_req            o_mem,
    input  logic [str_pkg::DATA_W-1:0]   i_rd_data
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DESC   = 8'b0000_0010,
        S_LEAF   = 8'b0000_0100,
        S_UPD_RD = 8'b0000_1000,
        S_UPD_WR = 8'b0001_0000,
        S_QRY    = 8'b0010_0000,
        S_QDRAIN = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    localparam logic [str_pkg::SP_W-1:0] SP_ONE = str_pkg::SP_W'(1);

    t_state                      r_state, n_state;
    str_pkg::t_node              r_node, n_node;
    logic [str_pkg::SP_W-1:0]    r_sp, n_sp;
    str_pkg::t_node              r_stack [str_pkg::STACK_DEPTH];
    logic [str_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [str_pkg::IDX_W-1:0]   r_lo, n_lo;
    logic [str_pkg::IDX_W-1:0]   r_hi, n_hi;
    logic [str_pkg::DATA_W-1:0]  r_amount, n_amount;
    logic [str_pkg::DATA_W-1:0]  r_delta, n_delta;
    logic [str_pkg::DATA_W-1:0]  r_acc, n_acc;
    logic                        r_pend, n_pend;
    logic [str_pkg::DATA_W-1:0]  r_sum, n_sum;
    logic                        r_status, n_status;
    logic                        r_out_valid, n_out_valid;
    logic [str_pkg::DATA_W-1:0]  r_out_sum, n_out_sum;
    logic                        r_out_status, n_out_status;

    str_pkg::t_split             split;
    str_pkg::t_node              root;
    str_pkg::t_node              stack_top;
    logic [str_pkg::IDX_W-1:0]   last_idx;
    logic [str_pkg::IDX_W-1:0]   clip_hi;
    logic                        accept;
    logic                        push;
    logic                        disjoint;
    logic                        covered;

    str_split u_split (
        .i_node  (r_node),
        .i_idx   (r_idx),
        .o_split (split)
    );

    assign i_req.ready = (r_state == S_IDLE) && i_run;
    assign accept      = i_req.valid && i_req.ready;
    assign last_idx    = str_pkg::IDX_W'(i_count - str_pkg::CNT_W'(1));
    assign root        = '{id: '0, first: '0, last: last_idx};
    assign stack_top   = r_stack[r_sp - SP_ONE];
    assign clip_hi     = (i_req.range_high > last_idx) ? last_idx : i_req.range_high;
    assign disjoint    = (r_lo > r_node.last) || (r_hi < r_node.first);
    assign covered     = (r_node.first >= r_lo) && (r_node.last <= r_hi);

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.range_sum = r_out_sum;
    assign o_rsp.status    = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_node       = r_node;
        n_sp         = r_sp;
        n_idx        = r_idx;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_amount     = r_amount;
        n_delta      = r_delta;
        n_acc        = r_acc + (r_pend ? i_rd_data : '0);
        n_pend       = 1'b0;
        n_sum        = r_sum;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_sum    = r_out_sum;
        n_out_status = r_out_status;
        push         = 1'b0;

        o_mem.rd_addr = r_node.id;
        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = r_node.id;
        o_mem.wr_data = i_rd_data + r_delta;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_node   = root;
                    n_sp     = '0;
                    n_acc    = '0;
                    n_idx    = i_req.element_index;
                    n_lo     = i_req.range_low;
                    n_hi     = clip_hi;
                    n_amount = i_req.amount;
                    n_delta  = i_req.amount;
                    n_sum    = '0;
                    n_status = 1'b0;
                    case (str_pkg::t_req_type'(i_req.req_type))
                        str_pkg::REQ_SET, str_pkg::REQ_ADD: begin
                            if ({1'b0, i_req.element_index} >= i_count) begin
                                n_status = 1'b1;
                                n_state  = S_DONE;
                            end else if (i_req.req_type == str_pkg::REQ_SET) begin
                                n_state = S_DESC;
                            end else begin
                                n_state = S_UPD_RD;
                            end
                        end
                        str_pkg::REQ_QUERY: begin
                            n_state = (i_req.range_low > clip_hi) ? S_DONE : S_QRY;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DESC: begin
                if (split.leaf) begin
                    n_state = S_LEAF;
                end else begin
                    n_node = split.go_left ? split.left : split.right;
                end
            end
            S_LEAF: begin
                n_delta = r_amount - i_rd_data;
                n_node  = root;
                n_state = S_UPD_RD;
            end
            S_UPD_RD: begin
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                o_mem.wr_en = 1'b1;
                if (split.leaf) begin
                    n_state = S_DONE;
                end else begin
                    n_node  = split.go_left ? split.left : split.right;
                    n_state = S_UPD_RD;
                end
            end
            S_QRY: begin
                if (disjoint || covered || split.leaf) begin
                    n_pend = covered && !disjoint;
                    if (r_sp == '0) begin
                        n_state = S_QDRAIN;
                    end else begin
                        n_node = stack_top;
                        n_sp   = r_sp - SP_ONE;
                    end
                end else begin
                    push   = 1'b1;
                    n_node = split.left;
                    n_sp   = r_sp + SP_ONE;
                end
            end
            S_QDRAIN: begin
                n_sum   = n_acc;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sum    = r_sum;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_idx        <= n_idx;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_amount     <= n_amount;
        r_delta      <= n_delta;
        r_acc        <= n_acc;
        r_sum        <= n_sum;
        r_status     <= n_status;
        r_out_sum    <= n_out_sum;
        r_out_status <= n_out_status;
        if (push) begin
            r_stack[r_sp] <= split.right;
        end
    end

endmodule
